FILE: rtl/timed_fault_confirmation_unit_defines.svh
// Assertion macros shared by the timed fault confirmation RTL.
`ifndef TIMED_FAULT_CONFIRMATION_UNIT_DEFINES_SVH
`define TIMED_FAULT_CONFIRMATION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TFC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TFC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfc assertion failed");

`endif

FILE: rtl/tfc_pkg.sv
// Types and constants for the timed fault confirmation unit.
package tfc_pkg;

    localparam int unsigned FaultCount = 5;
    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned CfgDataWidth = 16;
    localparam int unsigned TimeWidth = 32;

    // Fault slots
    localparam int unsigned SlotComm = 0;
    localparam int unsigned SlotBridge = 1;
    localparam int unsigned SlotHeartbeat = 2;
    localparam int unsigned SlotVoltage = 3;
    localparam int unsigned SlotTemperature = 4;

    localparam logic [7:0] BridgeFailCode = 8'hFF;

    localparam logic [CfgDataWidth-1:0] CommConfirmReset = 16'd500;
    localparam logic [CfgDataWidth-1:0] VoltageConfirmReset = 16'd500;
    localparam logic [CfgDataWidth-1:0] TemperatureConfirmReset = 16'd1000;
    localparam logic [CfgDataWidth-1:0] PinTimeoutReset = 16'd1000;

    typedef enum logic [1:0] {
        OP_EVALUATE  = 2'd0,
        OP_PIN       = 2'd1,
        OP_CLEAR_ALL = 2'd2,
        OP_CLEAR_ONE = 2'd3
    } tfc_opcode_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_COMM_CONFIRM  = 2'd0,
        CFG_VOLT_CONFIRM  = 2'd1,
        CFG_TEMP_CONFIRM  = 2'd2,
        CFG_PIN_TIMEOUT   = 2'd3
    } tfc_cfg_index_t;

    localparam logic [2:0] ClrComm = 3'd0;
    localparam logic [2:0] ClrVoltage = 3'd1;
    localparam logic [2:0] ClrTemperature = 3'd2;
    localparam logic [2:0] ClrBridge = 3'd3;
    localparam logic [2:0] ClrHeartbeat = 3'd4;
    localparam logic [2:0] ClrUnspecified = 3'd5;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [TimeWidth-1:0] now_ms;
        logic                 comm_fail;
        logic [7:0]           bridge_summary;
        logic                 heartbeat_ok;
        logic                 over_voltage;
        logic                 under_voltage;
        logic                 over_temperature;
        logic                 under_temperature;
        logic                 pin_low;
        logic [2:0]           clear_target;
    } tfc_in_t;

    typedef struct packed {
        logic comm_confirmed;
        logic bridge_confirmed;
        logic heartbeat_confirmed;
        logic voltage_confirmed;
        logic temperature_confirmed;
        logic unspecified_confirmed;
        logic overall_fault;
        logic overall_changed;
    } tfc_out_t;

    // Per-slot control from the top level to one fault timer
    typedef struct packed {
        logic fire;     // item executes this cycle
        logic watch;    // evaluate opcode: track the condition
        logic present;  // raw condition
        logic clear;    // clear command hits this slot
    } tfc_slot_ctrl_t;

endpackage

FILE: rtl/tfc_in_if.sv
// Input item channel of the timed fault confirmation unit.
interface tfc_in_if;
    logic             valid;
    logic             ready;
    tfc_pkg::tfc_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tfc_out_if.sv
// Result item channel of the timed fault confirmation unit.
interface tfc_out_if;
    logic              valid;
    logic              ready;
    tfc_pkg::tfc_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tfc_fault_timer.sv
// Persistence timer and confirmation latch for one fault condition.
module tfc_fault_timer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tfc_pkg::tfc_slot_ctrl_t         ctrl,
    input  logic [tfc_pkg::TimeWidth-1:0]   now_ms,
    input  logic [tfc_pkg::CfgDataWidth-1:0] limit_ms,
    output logic                            flag_next
);

    logic [tfc_pkg::TimeWidth-1:0] start_reg;
    logic [tfc_pkg::TimeWidth-1:0] start_next;
    logic                          valid_reg;
    logic                          valid_next;
    logic                          flag_reg;
    logic [tfc_pkg::TimeWidth-1:0] elapsed;

    // A fresh start gives zero elapsed time, so it never confirms at once
    assign elapsed = valid_reg ? (now_ms - start_reg) : '0;

    always_comb
    begin
        start_next = start_reg;
        valid_next = valid_reg;
        flag_next  = flag_reg;
        if (ctrl.fire)
        begin
            if (ctrl.watch)
            begin
                if (ctrl.present)
                begin
                    if (!valid_reg)
                    begin
                        start_next = now_ms;
                        valid_next = 1'b1;
                    end
                    if (elapsed > {{(tfc_pkg::TimeWidth-tfc_pkg::CfgDataWidth){1'b0}},
                                   limit_ms})
                    begin
                        flag_next = 1'b1;
                    end
                end
                else
                begin
                    valid_next = 1'b0;
                    flag_next  = 1'b0;
                end
            end
            else if (ctrl.clear)
            begin
                valid_next = 1'b0;
                flag_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
    end

endmodule

FILE: rtl/timed_fault_confirmation_unit.sv
// Timed fault confirmation unit: top level.
//
// Items arrive on req (valid/ready) and each gives exactly one result on rsp.
// An item is registered in the input register on the transfer, executed against
// the fault state once the output register is free or rsp is ready, and its
// result is written to the output register at the end of that cycle.
// Throughput is one item per cycle while rsp is not stalled; all five
// persistence checks and the pin timeout check are done in parallel by one
// subtract and compare each. When rsp is stalled the result holds in the output
// register, the item behind it holds in the input register, and req.ready drops
// only when both are full.
// Configuration (cfg_write, cfg_index, cfg_data) writes one of the four
// millisecond limits; write it only while no item is in flight.
// Reset (rst_n low, asynchronous) clears all confirmations, the start-mark valids,
// the pin timer valid and both pipeline valids, and loads the default limits.
`include "timed_fault_confirmation_unit_defines.svh"

module timed_fault_confirmation_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    tfc_in_if.sink                               req,
    tfc_out_if.source                            rsp,
    input  logic                                 cfg_write,
    input  logic [tfc_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [tfc_pkg::CfgDataWidth-1:0]     cfg_data
);

    // Configuration registers
    logic [tfc_pkg::CfgDataWidth-1:0] comm_limit_reg;
    logic [tfc_pkg::CfgDataWidth-1:0] volt_limit_reg;
    logic [tfc_pkg::CfgDataWidth-1:0] temp_limit_reg;
    logic [tfc_pkg::CfgDataWidth-1:0] pin_limit_reg;

    // Pipeline registers
    logic              in_valid_reg;
    tfc_pkg::tfc_in_t  in_data_reg;
    logic              out_valid_reg;
    tfc_pkg::tfc_out_t out_data_reg;
    tfc_pkg::tfc_out_t out_data_next;
    logic              advance;

    // Pin and summary state
    logic                          pin_asserted_reg;
    logic                          pin_asserted_next;
    logic [tfc_pkg::TimeWidth-1:0] pin_start_reg;
    logic [tfc_pkg::TimeWidth-1:0] pin_start_next;
    logic                          pin_valid_reg;
    logic                          pin_valid_next;
    logic                          unspec_reg;
    logic                          unspec_next;
    logic                          last_overall_reg;
    logic                          overall;

    tfc_pkg::tfc_slot_ctrl_t          slot_ctrl [tfc_pkg::FaultCount];
    logic [tfc_pkg::CfgDataWidth-1:0] slot_limit [tfc_pkg::FaultCount];
    logic [tfc_pkg::FaultCount-1:0]   flag_next;
    logic [tfc_pkg::FaultCount-1:0]   slot_present;
    logic [tfc_pkg::FaultCount-1:0]   slot_clear;
    logic                             is_eval;
    logic                             is_clear_all;
    logic                             is_clear_one;
    logic                             any_specific;
    logic [tfc_pkg::TimeWidth-1:0]    pin_elapsed;
    logic                             rsp_specific;
    logic                             rsp_any;

    assign advance = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.data = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comm_limit_reg <= tfc_pkg::CommConfirmReset;
            volt_limit_reg <= tfc_pkg::VoltageConfirmReset;
            temp_limit_reg <= tfc_pkg::TemperatureConfirmReset;
            pin_limit_reg  <= tfc_pkg::PinTimeoutReset;
        end
        else if (cfg_write)
        begin
            case (tfc_pkg::tfc_cfg_index_t'(cfg_index))
                tfc_pkg::CFG_COMM_CONFIRM: comm_limit_reg <= cfg_data;
                tfc_pkg::CFG_VOLT_CONFIRM: volt_limit_reg <= cfg_data;
                tfc_pkg::CFG_TEMP_CONFIRM: temp_limit_reg <= cfg_data;
                tfc_pkg::CFG_PIN_TIMEOUT:  pin_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Opcode decode
    assign is_eval      = in_data_reg.opcode == tfc_pkg::OP_EVALUATE;
    assign is_clear_all = in_data_reg.opcode == tfc_pkg::OP_CLEAR_ALL;
    assign is_clear_one = in_data_reg.opcode == tfc_pkg::OP_CLEAR_ONE;

    always_comb
    begin
        slot_present[tfc_pkg::SlotComm]        = in_data_reg.comm_fail;
        slot_present[tfc_pkg::SlotBridge]      =
            in_data_reg.bridge_summary == tfc_pkg::BridgeFailCode;
        slot_present[tfc_pkg::SlotHeartbeat]   = !in_data_reg.heartbeat_ok;
        slot_present[tfc_pkg::SlotVoltage]     =
            in_data_reg.over_voltage | in_data_reg.under_voltage;
        slot_present[tfc_pkg::SlotTemperature] =
            in_data_reg.over_temperature | in_data_reg.under_temperature;

        slot_clear[tfc_pkg::SlotComm]        = is_clear_all ||
            (is_clear_one && in_data_reg.clear_target == tfc_pkg::ClrComm);
        slot_clear[tfc_pkg::SlotBridge]      = is_clear_all ||
            (is_clear_one && in_data_reg.clear_target == tfc_pkg::ClrBridge);
        slot_clear[tfc_pkg::SlotHeartbeat]   = is_clear_all ||
            (is_clear_one && in_data_reg.clear_target == tfc_pkg::ClrHeartbeat);
        slot_clear[tfc_pkg::SlotVoltage]     = is_clear_all ||
            (is_clear_one && in_data_reg.clear_target == tfc_pkg::ClrVoltage);
        slot_clear[tfc_pkg::SlotTemperature] = is_clear_all ||
            (is_clear_one && in_data_reg.clear_target == tfc_pkg::ClrTemperature);

        slot_limit[tfc_pkg::SlotComm]        = comm_limit_reg;
        slot_limit[tfc_pkg::SlotBridge]      = comm_limit_reg;
        slot_limit[tfc_pkg::SlotHeartbeat]   = comm_limit_reg;
        slot_limit[tfc_pkg::SlotVoltage]     = volt_limit_reg;
        slot_limit[tfc_pkg::SlotTemperature] = temp_limit_reg;
    end

    for (genvar g = 0; g < tfc_pkg::FaultCount; g++)
    begin : g_slot
        assign slot_ctrl[g] = '{fire: advance, watch: is_eval,
                                present: slot_present[g], clear: slot_clear[g]};

        tfc_fault_timer u_timer (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (slot_ctrl[g]),
            .now_ms    (in_data_reg.now_ms),
            .limit_ms  (slot_limit[g]),
            .flag_next (flag_next[g])
        );
    end

    assign any_specific = |flag_next;
    assign pin_elapsed = in_data_reg.now_ms - pin_start_reg;

    always_comb
    begin
        pin_asserted_next = pin_asserted_reg;
        pin_start_next    = pin_start_reg;
        pin_valid_next    = pin_valid_reg;
        unspec_next       = unspec_reg;
        case (tfc_pkg::tfc_opcode_t'(in_data_reg.opcode))
            tfc_pkg::OP_EVALUATE:
            begin
                if (any_specific)
                begin
                    unspec_next = 1'b0;
                end
                else if (pin_asserted_reg && pin_valid_reg && pin_elapsed >
                         {{(tfc_pkg::TimeWidth-tfc_pkg::CfgDataWidth){1'b0}},
                          pin_limit_reg})
                begin
                    unspec_next = 1'b1;
                end
            end
            tfc_pkg::OP_PIN:
            begin
                pin_asserted_next = in_data_reg.pin_low;
                if (in_data_reg.pin_low)
                begin
                    if (!pin_valid_reg)
                    begin
                        pin_start_next = in_data_reg.now_ms;
                        pin_valid_next = 1'b1;
                    end
                end
                else
                begin
                    pin_valid_next = 1'b0;
                    unspec_next    = 1'b0;
                end
            end
            tfc_pkg::OP_CLEAR_ALL:
            begin
                unspec_next = 1'b0;
            end
            tfc_pkg::OP_CLEAR_ONE:
            begin
                if (in_data_reg.clear_target == tfc_pkg::ClrUnspecified)
                begin
                    unspec_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign overall = any_specific || unspec_next;

    always_comb
    begin
        out_data_next.comm_confirmed        = flag_next[tfc_pkg::SlotComm];
        out_data_next.bridge_confirmed      = flag_next[tfc_pkg::SlotBridge];
        out_data_next.heartbeat_confirmed   = flag_next[tfc_pkg::SlotHeartbeat];
        out_data_next.voltage_confirmed     = flag_next[tfc_pkg::SlotVoltage];
        out_data_next.temperature_confirmed = flag_next[tfc_pkg::SlotTemperature];
        out_data_next.unspecified_confirmed = unspec_next;
        out_data_next.overall_fault         = overall;
        out_data_next.overall_changed       = overall != last_overall_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pin_asserted_reg <= 1'b0;
            pin_valid_reg    <= 1'b0;
            unspec_reg       <= 1'b0;
            last_overall_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                pin_asserted_reg <= pin_asserted_next;
                pin_valid_reg    <= pin_valid_next;
                unspec_reg       <= unspec_next;
                last_overall_reg <= overall;
            end
            else if (rsp.ready)
            begin
                // drop the result once transferred
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_data_reg <= req.data;
        end
        if (advance)
        begin
            out_data_reg  <= out_data_next;
            pin_start_reg <= pin_start_next;
        end
    end

    assign rsp_specific = rsp.data.comm_confirmed || rsp.data.bridge_confirmed ||
                          rsp.data.heartbeat_confirmed || rsp.data.voltage_confirmed ||
                          rsp.data.temperature_confirmed;
    assign rsp_any = rsp_specific || rsp.data.unspecified_confirmed;

    `TFC_ASSERT_IMP(a_overall_is_or, rsp.valid, rsp.data.overall_fault == rsp_any)
    `TFC_ASSERT_IMP(a_unspec_excl, rsp.valid && rsp.data.unspecified_confirmed, !rsp_specific)
    `TFC_ASSERT_IMP(a_unspec_needs_pin, $rose(unspec_reg), pin_asserted_reg && pin_valid_reg)
    `TFC_ASSERT_NXT(a_advance_fills_out, advance, out_valid_reg)

endmodule

FILE: dv/fault_flag_checker.sv
// Predicts the confirmed fault flags for every accepted item and checks each result.
module fault_flag_checker
    import tfc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    tfc_in_if                        req,
    tfc_out_if                       rsp,
    input  logic                     cfg_write,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    output int                       fail_count,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CfgDataWidth-1:0] comm_limit;
    logic [CfgDataWidth-1:0] volt_limit;
    logic [CfgDataWidth-1:0] temp_limit;
    logic [CfgDataWidth-1:0] pin_limit;

    logic [TimeWidth-1:0] since [FaultCount];
    logic [FaultCount-1:0] since_ok;
    logic [FaultCount-1:0] latched;
    logic                  unspec;
    logic                  pin_held;
    logic [TimeWidth-1:0]  pin_since;
    logic                  pin_since_ok;
    logic                  prev_overall;

    tfc_out_t flags_due [$];
    int errors = 0;
    int due_depth = 0;

    assign fail_count = errors;
    assign pending = due_depth;

    function automatic void drop(int unsigned slot);
        since[slot] = '0;
        since_ok[slot] = 1'b0;
        latched[slot] = 1'b0;
    endfunction

    function automatic void track(int unsigned slot, logic present,
                                  logic [TimeWidth-1:0] t_ms,
                                  logic [CfgDataWidth-1:0] limit);
        logic [TimeWidth-1:0] elapsed;
        if (present)
        begin
            if (!since_ok[slot])
            begin
                since[slot] = t_ms;
                since_ok[slot] = 1'b1;
            end
            elapsed = t_ms - since[slot];
            if (!latched[slot] && elapsed > {16'd0, limit})
                latched[slot] = 1'b1;
        end
        else
            drop(slot);
    endfunction

    function automatic tfc_out_t next_fault_flags(tfc_in_t it);
        tfc_out_t flags;
        logic [TimeWidth-1:0] pin_elapsed;
        logic overall;
        case (it.opcode)
            OP_EVALUATE:
            begin
                track(SlotComm, it.comm_fail, it.now_ms, comm_limit);
                track(SlotBridge, it.bridge_summary == BridgeFailCode, it.now_ms, comm_limit);
                track(SlotHeartbeat, !it.heartbeat_ok, it.now_ms, comm_limit);
                track(SlotVoltage, it.over_voltage | it.under_voltage, it.now_ms, volt_limit);
                track(SlotTemperature, it.over_temperature | it.under_temperature,
                      it.now_ms, temp_limit);
                pin_elapsed = it.now_ms - pin_since;
                if (pin_held && pin_since_ok && latched == '0 && !unspec &&
                    pin_elapsed > {16'd0, pin_limit})
                    unspec = 1'b1;
                // a confirmed specific fault overrides the pin timeout
                if (latched != '0)
                    unspec = 1'b0;
            end
            OP_PIN:
            begin
                pin_held = it.pin_low;
                if (it.pin_low)
                begin
                    if (!pin_since_ok)
                    begin
                        pin_since = it.now_ms;
                        pin_since_ok = 1'b1;
                    end
                end
                else
                begin
                    pin_since = '0;
                    pin_since_ok = 1'b0;
                    unspec = 1'b0;
                end
            end
            OP_CLEAR_ALL:
            begin
                for (int k = 0; k < FaultCount; k++)
                    drop(k);
                unspec = 1'b0;
            end
            default:
            begin
                case (it.clear_target)
                    ClrComm:        drop(SlotComm);
                    ClrVoltage:     drop(SlotVoltage);
                    ClrTemperature: drop(SlotTemperature);
                    ClrBridge:      drop(SlotBridge);
                    ClrHeartbeat:   drop(SlotHeartbeat);
                    ClrUnspecified: unspec = 1'b0;
                    default:        ;
                endcase
            end
        endcase

        overall = (latched != '0) || unspec;
        flags.comm_confirmed = latched[SlotComm];
        flags.bridge_confirmed = latched[SlotBridge];
        flags.heartbeat_confirmed = latched[SlotHeartbeat];
        flags.voltage_confirmed = latched[SlotVoltage];
        flags.temperature_confirmed = latched[SlotTemperature];
        flags.unspecified_confirmed = unspec;
        flags.overall_fault = overall;
        flags.overall_changed = overall != prev_overall;
        prev_overall = overall;
        return flags;
    endfunction

    function automatic void check_field(string name, logic want, logic got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %b, got %b", $time, name, want, got);
        end
    endfunction

    function automatic void check_flags(tfc_out_t want, tfc_out_t got);
        check_field("comm_confirmed", want.comm_confirmed, got.comm_confirmed);
        check_field("bridge_confirmed", want.bridge_confirmed, got.bridge_confirmed);
        check_field("heartbeat_confirmed", want.heartbeat_confirmed, got.heartbeat_confirmed);
        check_field("voltage_confirmed", want.voltage_confirmed, got.voltage_confirmed);
        check_field("temperature_confirmed", want.temperature_confirmed,
                    got.temperature_confirmed);
        check_field("unspecified_confirmed", want.unspecified_confirmed,
                    got.unspecified_confirmed);
        check_field("overall_fault", want.overall_fault, got.overall_fault);
        check_field("overall_changed", want.overall_changed, got.overall_changed);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comm_limit = CommConfirmReset;
            volt_limit = VoltageConfirmReset;
            temp_limit = TemperatureConfirmReset;
            pin_limit = PinTimeoutReset;
            for (int k = 0; k < FaultCount; k++)
                drop(k);
            unspec = 1'b0;
            pin_held = 1'b0;
            pin_since = '0;
            pin_since_ok = 1'b0;
            prev_overall = 1'b0;
            flags_due.delete();
            due_depth <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_COMM_CONFIRM: comm_limit = cfg_data;
                    CFG_VOLT_CONFIRM: volt_limit = cfg_data;
                    CFG_TEMP_CONFIRM: temp_limit = cfg_data;
                    CFG_PIN_TIMEOUT:  pin_limit = cfg_data;
                    default:          ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (flags_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected, expected nothing, got %b",
                             $time, rsp.data);
                end
                else
                    check_flags(flags_due.pop_front(), rsp.data);
            end
            if (req.valid && req.ready)
                flags_due.push_back(next_fault_flags(req.data));
            due_depth <= flags_due.size();
        end
    end
endmodule

FILE: dv/tb_timed_fault_confirmation_unit.sv
// Top of the timed fault confirmation testbench: clock, reset, stimulus and verdict.
module tb_timed_fault_confirmation_unit
    import tfc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 200000;
    localparam int LongHoldCycles = 150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                     cfg_write;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_data;

    int flags_pending;
    int flag_errors;
    int results_seen = 0;
    bit calm_tx = 1'b0;
    bit calm_rx = 1'b0;
    logic [TimeWidth-1:0] clock_ms;

    tfc_in_if req_ch();
    tfc_out_if rsp_ch();

    timed_fault_confirmation_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fault_flag_checker flag_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (flag_errors),
        .pending    (flags_pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin : watchdog
        int cycles = 0;
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random stalls, calm stretches, and two long hold-offs
    initial
    begin : drain
        int stall;
        rsp_ch.ready = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                calm_rx = !calm_rx;
            stall = calm_rx ? 0 : $urandom_range(0, 7);
            if (results_seen == 300 || results_seen == 900)
                stall = LongHoldCycles;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            results_seen++;
        end
    end

    function automatic tfc_in_t noise_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return tfc_in_t'(r[$bits(tfc_in_t)-1:0]);
    endfunction

    // c: comm, bridge, heartbeat lost, over_v, under_v, over_t, under_t (bit 0 up)
    function automatic tfc_in_t eval_item(logic [TimeWidth-1:0] t_ms, logic [6:0] c);
        tfc_in_t it;
        it = noise_item();
        it.opcode = OP_EVALUATE;
        it.now_ms = t_ms;
        it.comm_fail = c[0];
        it.bridge_summary = c[1] ? BridgeFailCode : 8'($urandom_range(0, 254));
        it.heartbeat_ok = !c[2];
        it.over_voltage = c[3];
        it.under_voltage = c[4];
        it.over_temperature = c[5];
        it.under_temperature = c[6];
        return it;
    endfunction

    function automatic tfc_in_t pin_item(logic [TimeWidth-1:0] t_ms, logic pin);
        tfc_in_t it;
        it = noise_item();
        it.opcode = OP_PIN;
        it.now_ms = t_ms;
        it.pin_low = pin;
        return it;
    endfunction

    function automatic tfc_in_t clear_one_item(logic [2:0] target);
        tfc_in_t it;
        it = noise_item();
        it.opcode = OP_CLEAR_ONE;
        it.clear_target = target;
        return it;
    endfunction

    function automatic tfc_in_t clear_all_item();
        tfc_in_t it;
        it = noise_item();
        it.opcode = OP_CLEAR_ALL;
        return it;
    endfunction

    task automatic send(input tfc_in_t it);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= it;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Drop valid and wait until every expected result is back
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (flags_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_limits(input logic [CfgDataWidth-1:0] comm_ms, volt_ms,
                                  temp_ms, pin_ms);
        tfc_cfg_index_t regs [4];
        logic [CfgDataWidth-1:0] vals [4];
        regs = '{CFG_COMM_CONFIRM, CFG_VOLT_CONFIRM, CFG_TEMP_CONFIRM, CFG_PIN_TIMEOUT};
        vals = '{comm_ms, volt_ms, temp_ms, pin_ms};
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(int count, int unsigned step_max, int unsigned appear_odds,
                             logic [TimeWidth-1:0] start_ms);
        logic [6:0] conds;
        logic pin;
        int unsigned roll;
        conds = '0;
        pin = 1'b0;
        clock_ms = start_ms;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                calm_tx = !calm_tx;

            // advance time, with rare jumps and steps back
            roll = $urandom_range(0, 99);
            if (roll == 0)
                clock_ms = $urandom;
            else if (roll == 1)
                clock_ms = clock_ms - $urandom_range(1, step_max);
            else
                clock_ms = clock_ms + $urandom_range(0, step_max);

            // hold conditions for a while so that some of them persist
            for (int b = 0; b < 7; b++)
            begin
                if (conds[b])
                    conds[b] = $urandom_range(0, 5) != 0;
                else
                    conds[b] = $urandom_range(1, appear_odds) == 1;
            end

            roll = $urandom_range(0, 99);
            if (roll < 68)
                send(eval_item(clock_ms, conds));
            else if (roll < 80)
            begin
                if ($urandom_range(0, 2) == 0)
                    pin = !pin;
                send(pin_item(clock_ms, pin));
            end
            else if (roll < 84)
                send(clear_all_item());
            else if (roll < 96)
                send(clear_one_item(3'($urandom_range(0, 7))));
            else
                send(noise_item());
        end
    endtask

    initial
    begin : stimulus
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        // default limits: comm 500, voltage 500, temperature 1000, pin 1000
        send(eval_item(32'd0, 7'h01));
        send(eval_item(32'd500, 7'h01));
        send(eval_item(32'd501, 7'h01));
        send(eval_item(32'd501, 7'h7F));
        send(eval_item(32'd1002, 7'h7F));
        send(eval_item(32'd1502, 7'h7F));
        for (int tgt = 0; tgt < 8; tgt++)
            send(clear_one_item(3'(tgt)));
        send(clear_all_item());
        send(eval_item(32'd2000, 7'h00));
        send(pin_item(32'd2000, 1'b1));
        send(eval_item(32'd3000, 7'h00));
        send(eval_item(32'd3001, 7'h00));
        // clear all keeps the pin timer, so the pin fault comes straight back
        send(clear_all_item());
        send(eval_item(32'd3002, 7'h00));
        send(eval_item(32'd3002, 7'h01));
        send(eval_item(32'd3503, 7'h01));
        send(pin_item(32'd3503, 1'b0));
        // elapsed time across the wrap of the millisecond counter
        send(eval_item(32'hFFFF_FF00, 7'h08));
        send(eval_item(32'h0000_0100, 7'h08));
        settle();

        // zero limits: confirm one millisecond after the start, never on it
        program_limits(16'd0, 16'd0, 16'd0, 16'd0);
        send(eval_item(32'd7, 7'h40));
        send(eval_item(32'd8, 7'h40));
        send(pin_item(32'd8, 1'b1));
        send(eval_item(32'd9, 7'h00));
        send(pin_item(32'd9, 1'b0));
        run_phase(236, 3, 20, $urandom);
        settle();

        program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(236, 12000, 8, 32'hFFF0_0000);
        settle();

        program_limits(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                       16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
        run_phase(236, 10, 60, $urandom);
        settle();

        program_limits(16'd0, 16'hFFFF, 16'd1, 16'd20);
        run_phase(236, 100, 10, $urandom);
        settle();

        program_limits(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                       16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)));
        run_phase(236, 50, 40, $urandom);
        settle();

        program_limits(CommConfirmReset, VoltageConfirmReset, TemperatureConfirmReset,
                       PinTimeoutReset);
        run_phase(236, 200, 60, $urandom);
        settle();

        repeat (10) @(posedge clk);
        if (flag_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: timed_fault_confirmation_unit.f
+incdir+rtl
rtl/tfc_pkg.sv
rtl/tfc_in_if.sv
rtl/tfc_out_if.sv
rtl/tfc_fault_timer.sv
rtl/timed_fault_confirmation_unit.sv
dv/fault_flag_checker.sv
dv/tb_timed_fault_confirmation_unit.sv
